@@ rtl/jswt_pkg.sv @@
// Shared types, widths and the ordering rule for the job scheduler.
// Used by job_schedule_weighted_tardiness; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package jswt_pkg;

	localparam int ID_W   = 8;
	localparam int DUR_W  = 8;
	localparam int DL_W   = 10;
	localparam int PRI_W  = 4;
	localparam int TIME_W = 12;
	localparam int PEN_W  = 20;
	localparam int PROD_W = PRI_W + TIME_W;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [PEN_W-1:0]  PEN_MAX  = '1;

	localparam logic POLICY_EDF = 1'b0;
	localparam logic POLICY_HPF = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] dur;
		logic [DL_W-1:0]  dl;
		logic [PRI_W-1:0] pri;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_MUL,
		ST_EMIT
	} state_t;

	// true when job a must go strictly ahead of job b
	function automatic logic goes_before(logic mode, job_t a, job_t b);
		logic res;
		if (mode == POLICY_EDF) begin
			res = (a.dl != b.dl) ? (a.dl < b.dl) : (a.pri > b.pri);
		end else begin
			res = (a.pri != b.pri) ? (a.pri > b.pri) : (a.dl < b.dl);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/job_schedule_weighted_tardiness.sv @@
// Job scheduler: loads a set of jobs, orders them by policy, emits the schedule with
// running start, finish and weighted tardiness. Depends on jswt_pkg.
// Loading: one job word per cycle; in_ready is high while idle.
// Scheduling n jobs: each result takes a full pass of the shared comparator over the job
// memory, then the CALC, MUL and EMIT states; EMIT waits for out_ready while a result is held.
// Reset clears counters, policy and handshakes; job memory is left undefined, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module job_schedule_weighted_tardiness #(
	parameter int MAX_JOBS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         policy_mode,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [jswt_pkg::ID_W-1:0]    job_id,
	input  wire logic [jswt_pkg::DUR_W-1:0]   job_duration,
	input  wire logic [jswt_pkg::DL_W-1:0]    job_deadline,
	input  wire logic [jswt_pkg::PRI_W-1:0]   job_priority,
	input  wire logic                         last_job,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [jswt_pkg::ID_W-1:0]         sched_id,
	output logic [jswt_pkg::TIME_W-1:0]       start_time,
	output logic [jswt_pkg::TIME_W-1:0]       finish_time,
	output logic [jswt_pkg::PEN_W-1:0]        penalty_total,
	output logic                              last_result
);
	import jswt_pkg::*;

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);

	state_t state_q, state_d;

	logic                policy_q;
	logic [CW-1:0]       job_count_q;
	logic [CW-1:0]       issue_q;
	logic [CW-1:0]       emit_q;
	logic [MAX_JOBS-1:0] used_q;
	logic [TIME_W-1:0]   time_q;
	logic [PEN_W-1:0]    pen_q;

	job_t                mem [MAX_JOBS];
	job_t                rd_s1;
	logic [IW-1:0]       cmp_idx_s1;
	logic                cmp_vld_s1;

	job_t                best_q;
	logic [IW-1:0]       best_idx_q;
	logic                have_best_q;

	logic [TIME_W-1:0]   fin_q;
	logic [TIME_W-1:0]   tard_q;
	logic [PROD_W-1:0]   prod_q;
	logic                out_valid_q;

	logic                in_acc;
	logic                store_en;
	logic                scan_issue;
	logic                scan_done;
	logic                load_out;
	logic                is_last;
	logic [TIME_W:0]     fin_sum;
	logic [TIME_W-1:0]   fin_sat;
	logic [TIME_W-1:0]   dl_ext;
	logic [PEN_W:0]      pen_sum;
	logic [PEN_W-1:0]    pen_sat;
	job_t                in_job;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign store_en  = in_acc && (job_count_q < CW'(MAX_JOBS));
	assign scan_issue = (state_q == ST_SCAN) && (issue_q < job_count_q);
	assign scan_done  = (state_q == ST_SCAN) && (issue_q == job_count_q) && !cmp_vld_s1;
	assign is_last    = (CW'(emit_q + 1'b1) == job_count_q);

	assign in_job.id  = job_id;
	assign in_job.dur = job_duration;
	assign in_job.dl  = job_deadline;
	assign in_job.pri = job_priority;

	assign fin_sum = {1'b0, time_q} + (TIME_W + 1)'(best_q.dur);
	assign fin_sat = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
	assign dl_ext  = TIME_W'(best_q.dl);
	assign pen_sum = {1'b0, pen_q} + (PEN_W + 1)'(prod_q);
	assign pen_sat = pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && last_job) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_CALC;
			end
			ST_CALC: state_d = ST_MUL;
			ST_MUL:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = is_last ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: load_out = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_EDF;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= policy_mode;
		end
	end

	// job memory: one write port on load, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (store_en) mem[job_count_q[IW-1:0]] <= in_job;
		if (scan_issue) rd_s1 <= mem[issue_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
			issue_q     <= '0;
			emit_q      <= '0;
			used_q      <= '0;
			time_q      <= '0;
			pen_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (store_en) job_count_q <= CW'(job_count_q + 1'b1);

			cmp_vld_s1 <= scan_issue;
			if (scan_issue) begin
				cmp_idx_s1 <= issue_q[IW-1:0];
				issue_q    <= CW'(issue_q + 1'b1);
			end

			// strict compare in load order keeps equal keys in load order
			if (cmp_vld_s1 && !used_q[cmp_idx_s1]) begin
				if (!have_best_q || goes_before(policy_q, rd_s1, best_q)) begin
					have_best_q <= 1'b1;
				end
			end

			if (state_q == ST_CALC) used_q[best_idx_q] <= 1'b1;

			if (load_out) begin
				out_valid_q <= 1'b1;
				issue_q     <= '0;
				have_best_q <= 1'b0;
				if (is_last) begin
					job_count_q <= '0;
					emit_q      <= '0;
					used_q      <= '0;
					time_q      <= '0;
					pen_q       <= '0;
				end else begin
					emit_q <= CW'(emit_q + 1'b1);
					time_q <= fin_q;
					pen_q  <= pen_sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// best candidate, arithmetic pipeline and output registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && !used_q[cmp_idx_s1]) begin
			if (!have_best_q || goes_before(policy_q, rd_s1, best_q)) begin
				best_q     <= rd_s1;
				best_idx_q <= cmp_idx_s1;
			end
		end
		if (state_q == ST_CALC) begin
			fin_q  <= fin_sat;
			tard_q <= (fin_sat > dl_ext) ? TIME_W'(fin_sat - dl_ext) : '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(best_q.pri) * PROD_W'(tard_q);
		end
		if (load_out) begin
			sched_id      <= best_q.id;
			start_time    <= time_q;
			finish_time   <= fin_q;
			penalty_total <= pen_sat;
			last_result   <= is_last;
		end
	end

	assign out_valid = out_valid_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_count_q <= CW'(MAX_JOBS))
		else $error("job count beyond store depth");

	a_best_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> have_best_q)
		else $error("scan finished without a candidate");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (emit_q < job_count_q))
		else $error("scan started with every job already emitted");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && is_last) |=> (job_count_q == '0 && used_q == '0 && state_q == ST_IDLE))
		else $error("set not cleared after final word");

	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !store_en)
		else $error("job stored while scheduling");

endmodule

`default_nettype wire
